// ===== src/minv_pkg.sv =====
package minv_pkg;

   // Number format and derived widths
   localparam int FRAC_BITS  = 16;
   localparam int ELEM_W     = 32;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int ADJ_W      = PROD_W + 1;
   localparam int ADJ_MAG_W  = PROD_W;
   // three products of at most 2^94 each stay below 2^96
   localparam int DET_MAG_W  = ADJ_MAG_W + ELEM_W;
   localparam int DET_W      = DET_MAG_W + 1;
   localparam int SHL_W      = ADJ_MAG_W + 2 * FRAC_BITS + 1;
   localparam int NUM_W      = ((SHL_W > DET_MAG_W) ? SHL_W : DET_MAG_W) + 1;
   localparam int DEN_W      = DET_MAG_W + 1;
   // top quotient bit marks a result that saturates
   localparam int QUO_W      = ELEM_W;
   localparam int CMP_W      = DEN_W + QUO_W;
   localparam int RND_W      = DET_MAG_W + 1 - 2 * FRAC_BITS;
   localparam int THR_W      = 31;

   // CSR port
   localparam int   CSR_DATA_W        = 32;
   localparam int   CSR_ADDR_W        = 3;
   localparam logic CSR_IDX_THRESHOLD = 1'b0;

   // Pipeline depths
   localparam int NUM_LANES = 9;
   localparam int COF_LAT   = 2;
   localparam int DET_LAT   = 5;
   localparam int DIV_LAT   = QUO_W + 1;
   localparam int PIPE_LAT  = 1 + COF_LAT + DET_LAT + DIV_LAT + 1;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a00;
      logic signed [ELEM_W-1:0] a01;
      logic signed [ELEM_W-1:0] a02;
      logic signed [ELEM_W-1:0] a10;
      logic signed [ELEM_W-1:0] a11;
      logic signed [ELEM_W-1:0] a12;
      logic signed [ELEM_W-1:0] a20;
      logic signed [ELEM_W-1:0] a21;
      logic signed [ELEM_W-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] b00;
      logic signed [ELEM_W-1:0] b01;
      logic signed [ELEM_W-1:0] b02;
      logic signed [ELEM_W-1:0] b10;
      logic signed [ELEM_W-1:0] b11;
      logic signed [ELEM_W-1:0] b12;
      logic signed [ELEM_W-1:0] b20;
      logic signed [ELEM_W-1:0] b21;
      logic signed [ELEM_W-1:0] b22;
      logic                     is_singular;
   } rsp_type;

   // operands of one 2x2 minor: x*y - z*w, negated for odd cofactor positions
   typedef struct packed {
      logic signed [ELEM_W-1:0] x;
      logic signed [ELEM_W-1:0] y;
      logic signed [ELEM_W-1:0] z;
      logic signed [ELEM_W-1:0] w;
      logic                     negate;
   } cof_ops_type;

   typedef struct packed {
      logic                 singular;
      logic                 neg;
      logic [DET_MAG_W-1:0] mag;
   } det_info_type;

   typedef struct packed {
      logic             singular;
      logic             neg;
      logic [QUO_W-1:0] quo;
   } lane_res_type;

   // Adjugate entry k (row-major) as a signed minor
   function automatic cof_ops_type cof_ops(input int k, input req_type m);
      cof_ops_type o;
      unique case (k)
         0: o = '{x: m.a11, y: m.a22, z: m.a12, w: m.a21, negate: 1'b0};
         1: o = '{x: m.a01, y: m.a22, z: m.a02, w: m.a21, negate: 1'b1};
         2: o = '{x: m.a01, y: m.a12, z: m.a02, w: m.a11, negate: 1'b0};
         3: o = '{x: m.a10, y: m.a22, z: m.a12, w: m.a20, negate: 1'b1};
         4: o = '{x: m.a00, y: m.a22, z: m.a02, w: m.a20, negate: 1'b0};
         5: o = '{x: m.a00, y: m.a12, z: m.a02, w: m.a10, negate: 1'b1};
         6: o = '{x: m.a10, y: m.a21, z: m.a11, w: m.a20, negate: 1'b0};
         7: o = '{x: m.a00, y: m.a21, z: m.a01, w: m.a20, negate: 1'b1};
         8: o = '{x: m.a00, y: m.a11, z: m.a01, w: m.a10, negate: 1'b0};
         default: o = '0;
      endcase
      return o;
   endfunction

   // Sign, saturation and singular zeroing of one lane's quotient
   function automatic logic signed [ELEM_W-1:0] lane_value(input lane_res_type r);
      logic [ELEM_W-1:0] mag;
      logic [ELEM_W-1:0] val;
      mag = {1'b0, r.quo[QUO_W-2:0]};
      if (r.singular) begin
         val = '0;
      end else if (r.quo[QUO_W-1]) begin
         val = r.neg ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
         val = r.neg ? (~mag + 1'b1) : mag;
      end
      return $signed(val);
   endfunction

endpackage

// ===== src/minv_cof.sv =====
module minv_cof (
   input  logic                                   clock,
   input  minv_pkg::cof_ops_type                  ops,
   output logic signed [minv_pkg::ADJ_W-1:0]      adj,
   output logic signed [minv_pkg::ADJ_W-1:0]      adj_late
);

   localparam int ADJ_W   = minv_pkg::ADJ_W;
   localparam int PROD_W  = minv_pkg::PROD_W;
   localparam int DET_LAT = minv_pkg::DET_LAT;

   logic signed [PROD_W-1:0] pxy_ff;
   logic signed [PROD_W-1:0] pzw_ff;
   logic                     negate_ff;
   logic signed [ADJ_W-1:0]  adj_ff;
   logic signed [ADJ_W-1:0]  adj_in;
   logic signed [ADJ_W-1:0]  adj_dly_ff [DET_LAT];

   // two products of the minor
   always_ff @(posedge clock) begin
      pxy_ff    <= $signed(ops.x) * $signed(ops.y);
      pzw_ff    <= $signed(ops.z) * $signed(ops.w);
      negate_ff <= ops.negate;
   end

   // difference, exact in one extra bit
   always_comb begin
      if (negate_ff) begin
         adj_in = ADJ_W'(pzw_ff) - ADJ_W'(pxy_ff);
      end else begin
         adj_in = ADJ_W'(pxy_ff) - ADJ_W'(pzw_ff);
      end
   end

   // hold the entry until the determinant is known
   always_ff @(posedge clock) begin
      adj_ff        <= adj_in;
      adj_dly_ff[0] <= adj_ff;
      for (int i = 1; i < DET_LAT; i++) begin
         adj_dly_ff[i] <= adj_dly_ff[i-1];
      end
   end

   assign adj      = adj_ff;
   assign adj_late = adj_dly_ff[DET_LAT-1];

endmodule

// ===== src/minv_det.sv =====
module minv_det (
   input  logic                                   clock,
   input  logic signed [minv_pkg::ELEM_W-1:0]     row0 [3],
   input  logic signed [minv_pkg::ADJ_W-1:0]      col0 [3],
   input  logic [minv_pkg::THR_W-1:0]             threshold,
   output minv_pkg::det_info_type                 info
);

   localparam int ELEM_W    = minv_pkg::ELEM_W;
   localparam int ADJ_W     = minv_pkg::ADJ_W;
   localparam int DET_W     = minv_pkg::DET_W;
   localparam int DET_MAG_W = minv_pkg::DET_MAG_W;
   localparam int RND_W     = minv_pkg::RND_W;
   localparam int FRAC_BITS = minv_pkg::FRAC_BITS;
   localparam logic [DET_MAG_W:0] HALF =
      {{DET_MAG_W{1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);

   logic signed [ADJ_W-1:0]   plo_ff  [3];
   logic signed [ADJ_W-1:0]   phi_ff  [3];
   logic signed [DET_W-1:0]   prod_ff [3];
   logic signed [DET_W-1:0]   det_ff;
   logic                      neg_ff;
   logic [DET_MAG_W-1:0]      mag_ff;
   logic [DET_MAG_W:0]        rnd_sum;
   logic [RND_W-1:0]          rnd_mag;
   minv_pkg::det_info_type    info_ff;

   // split 32 x 65 products into two 32 x 33 halves
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         plo_ff[j] <= row0[j] * $signed({1'b0, col0[j][ELEM_W-1:0]});
         phi_ff[j] <= row0[j] * $signed(col0[j][ADJ_W-1:ELEM_W]);
      end
   end

   // recombine halves, then sum along row 0
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         prod_ff[j] <= (DET_W'(phi_ff[j]) <<< ELEM_W) + DET_W'(plo_ff[j]);
      end
      det_ff <= prod_ff[0] + prod_ff[1] + prod_ff[2];
   end

   // magnitude and sign
   always_ff @(posedge clock) begin
      neg_ff <= det_ff[DET_W-1];
      mag_ff <= det_ff[DET_W-1] ? DET_MAG_W'(-det_ff) : DET_MAG_W'(det_ff);
   end

   // round to entry format, ties away from zero, and test the threshold
   always_comb begin
      rnd_sum = {1'b0, mag_ff} + HALF;
      rnd_mag = rnd_sum[DET_MAG_W:2*FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      info_ff.singular <= rnd_mag <= RND_W'(threshold);
      info_ff.neg      <= neg_ff;
      info_ff.mag      <= mag_ff;
   end

   assign info = info_ff;

endmodule

// ===== src/minv_div.sv =====
module minv_div (
   input  logic                                   clock,
   input  logic signed [minv_pkg::ADJ_W-1:0]      adj,
   input  minv_pkg::det_info_type                 info,
   output minv_pkg::lane_res_type                 res
);

   localparam int ADJ_W     = minv_pkg::ADJ_W;
   localparam int ADJ_MAG_W = minv_pkg::ADJ_MAG_W;
   localparam int NUM_W     = minv_pkg::NUM_W;
   localparam int DEN_W     = minv_pkg::DEN_W;
   localparam int QUO_W     = minv_pkg::QUO_W;
   localparam int CMP_W     = minv_pkg::CMP_W;
   localparam int FRAC_BITS = minv_pkg::FRAC_BITS;

   typedef struct packed {
      logic singular;
      logic neg;
   } ctl_type;

   logic [ADJ_MAG_W-1:0] adj_mag;
   logic [NUM_W-1:0]     rem_ff [QUO_W];
   logic [DEN_W-1:0]     den_ff [QUO_W];
   logic [QUO_W-1:0]     quo_ff [QUO_W+1];
   ctl_type              ctl_ff [QUO_W+1];

   // numerator 2*|adj|*2^(2F) + |det|, divisor 2*|det|: rounds the quotient
   assign adj_mag = adj[ADJ_W-1] ? ADJ_MAG_W'(-adj) : ADJ_MAG_W'(adj);

   always_ff @(posedge clock) begin
      rem_ff[0] <= NUM_W'({adj_mag, {(2*FRAC_BITS){1'b0}}, 1'b0})
                   + NUM_W'(info.mag);
      den_ff[0] <= {info.mag, 1'b0};
      quo_ff[0] <= '0;
      ctl_ff[0] <= '{singular: info.singular, neg: adj[ADJ_W-1] ^ info.neg};
   end

   // restoring division, one quotient bit per stage, MSB first
   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      localparam int SH = QUO_W - 1 - s;
      logic [CMP_W-1:0] trial;
      logic             take;

      always_comb begin
         trial = CMP_W'(den_ff[s]) << SH;
         take  = CMP_W'(rem_ff[s]) >= trial;
      end

      always_ff @(posedge clock) begin
         quo_ff[s+1] <= {quo_ff[s][QUO_W-2:0], take};
         ctl_ff[s+1] <= ctl_ff[s];
      end

      if (s < QUO_W - 1) begin : g_fwd
         logic [CMP_W-1:0] diff;

         assign diff = CMP_W'(rem_ff[s]) - trial;

         always_ff @(posedge clock) begin
            rem_ff[s+1] <= take ? NUM_W'(diff) : rem_ff[s];
            den_ff[s+1] <= den_ff[s];
         end
      end
   end

   assign res = '{singular: ctl_ff[QUO_W].singular,
                  neg:      ctl_ff[QUO_W].neg,
                  quo:      quo_ff[QUO_W]};

endmodule

// ===== src/matrix3x3_inverse_top.sv =====
// 3x3 matrix inverse, signed Q16.16, by adjugate over determinant.
//
// Request channel: a request is taken on each rising edge with start high
// and busy low. busy stays low, so one matrix may be started every cycle.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data;
// results leave in request order and the receiver cannot stall them.
// A request passes through the input register, the cofactor multipliers, the
// determinant unit, the divider lanes (one quotient bit per stage in each of
// nine lanes) and the merge register on its way to the result edge.
// Throughput is one matrix per cycle, set by the fully pipelined dividers.
// A matrix whose rounded determinant magnitude is at or below the threshold
// register comes back with is_singular set and all entries zero.
// CSR: threshold at byte address 0 (31 bits), written through the APB port.
// The user must write it only while no request is in flight; the block does
// not enforce it. Reset clears the threshold to zero and drops every request
// in flight; no result appears after reset until a new request is started.
module matrix3x3_inverse_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  minv_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output minv_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [minv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [minv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [minv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int ELEM_W     = minv_pkg::ELEM_W;
   localparam int ADJ_W      = minv_pkg::ADJ_W;
   localparam int THR_W      = minv_pkg::THR_W;
   localparam int CSR_DATA_W = minv_pkg::CSR_DATA_W;
   localparam int CSR_ADDR_W = minv_pkg::CSR_ADDR_W;
   localparam int NUM_LANES  = minv_pkg::NUM_LANES;
   localparam int COF_LAT    = minv_pkg::COF_LAT;
   localparam int DET_LAT    = minv_pkg::DET_LAT;
   localparam int PIPE_LAT   = minv_pkg::PIPE_LAT;
   localparam int DET_STAGE  = COF_LAT + DET_LAT;

   logic [THR_W-1:0]          thr_ff;
   logic [THR_W-1:0]          thr_in;
   logic                      csr_write;
   logic                      csr_hit;
   logic [PIPE_LAT-1:0]       vld_ff;
   logic [PIPE_LAT-1:0]       vld_in;
   minv_pkg::req_type         req_ff;
   logic signed [ELEM_W-1:0]  row_dly_ff [COF_LAT][3];
   logic signed [ADJ_W-1:0]   adj      [NUM_LANES];
   logic signed [ADJ_W-1:0]   adj_late [NUM_LANES];
   logic signed [ELEM_W-1:0]  det_row  [3];
   logic signed [ADJ_W-1:0]   det_col  [3];
   minv_pkg::det_info_type    det_info;
   minv_pkg::lane_res_type    lane_res [NUM_LANES];
   logic signed [ELEM_W-1:0]  lane_val [NUM_LANES];
   minv_pkg::rsp_type         rsp_in;
   minv_pkg::rsp_type         rsp_ff;

   // CSR access: the register index is the word address
   assign csr_hit   = paddr[CSR_ADDR_W-1] == minv_pkg::CSR_IDX_THRESHOLD;
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign thr_in    = csr_write ? pwdata[THR_W-1:0] : thr_ff;
   assign prdata    = csr_hit ? {{(CSR_DATA_W-THR_W){1'b0}}, thr_ff} : '0;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // request tracking through the pipeline
   assign busy   = 1'b0;
   assign vld_in = {vld_ff[PIPE_LAT-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // input register and row 0 delay for the determinant
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      row_dly_ff[0][0] <= req_ff.a00;
      row_dly_ff[0][1] <= req_ff.a01;
      row_dly_ff[0][2] <= req_ff.a02;
      for (int i = 1; i < COF_LAT; i++) begin
         row_dly_ff[i] <= row_dly_ff[i-1];
      end
   end

   // cofactor lanes
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_cof
      minv_pkg::cof_ops_type ops;
      assign ops = minv_pkg::cof_ops(k, req_ff);

      minv_cof u_cof (
         .clock    (clock),
         .ops      (ops),
         .adj      (adj[k]),
         .adj_late (adj_late[k])
      );
   end

   // determinant from row 0 and adjugate column 0
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         det_row[j] = row_dly_ff[COF_LAT-1][j];
         det_col[j] = adj[3*j];
      end
   end

   minv_det u_det (
      .clock     (clock),
      .row0      (det_row),
      .col0      (det_col),
      .threshold (thr_ff),
      .info      (det_info)
   );

   // divider lanes
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_div
      minv_div u_div (
         .clock (clock),
         .adj   (adj_late[k]),
         .info  (det_info),
         .res   (lane_res[k])
      );
      assign lane_val[k] = minv_pkg::lane_value(lane_res[k]);
   end

   // merge lanes into the result
   always_comb begin
      rsp_in.b00         = lane_val[0];
      rsp_in.b01         = lane_val[1];
      rsp_in.b02         = lane_val[2];
      rsp_in.b10         = lane_val[3];
      rsp_in.b11         = lane_val[4];
      rsp_in.b12         = lane_val[5];
      rsp_in.b20         = lane_val[6];
      rsp_in.b21         = lane_val[7];
      rsp_in.b22         = lane_val[8];
      rsp_in.is_singular = lane_res[0].singular;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[PIPE_LAT-1];
   assign rsp_data  = rsp_ff;

   // every result traces back to a request a fixed latency earlier
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_LAT))
      else $error("result without matching request");

   // a singular result carries only zeros
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_singular) |->
         (rsp_data.b00 == 0 && rsp_data.b01 == 0 && rsp_data.b02 == 0 &&
          rsp_data.b10 == 0 && rsp_data.b11 == 0 && rsp_data.b12 == 0 &&
          rsp_data.b20 == 0 && rsp_data.b21 == 0 && rsp_data.b22 == 0))
      else $error("singular result with nonzero entry");

   // dividers never see a zero divisor on a live request that is not singular
   a_nonzero_div: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DET_STAGE] && !det_info.singular) |-> (det_info.mag != 0))
      else $error("zero determinant passed as regular");

endmodule
